[rtl/core/ssge_pkg.sv]
`default_nettype none
package ssge_pkg;

  localparam int unsigned NUM_DIGITS = 6;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned SEG_W      = 7;
  localparam int unsigned SHIFT_W    = 3;
  localparam int unsigned S_TDATA_W  = 56;  // 6 x 8 char bits + 3 shift bits, padded
  localparam int unsigned M_TDATA_W  = 48;  // 6 x 7 segment bits, padded
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;

  typedef logic [SEG_W-1:0]   seg_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [SHIFT_W-1:0] shift_t;

  localparam seg_t SEG_BLANK = 7'h7F;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UPSIDE_DOWN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_OFF = 1'b1;

  // vertical shift codes, anything above highest acts as highest
  localparam shift_t SHIFT_LOWEST  = 3'd0;
  localparam shift_t SHIFT_LOW     = 3'd1;
  localparam shift_t SHIFT_NORMAL  = 3'd2;
  localparam shift_t SHIFT_HIGH    = 3'd3;
  localparam shift_t SHIFT_HIGHEST = 3'd4;

  typedef struct packed {
    logic upside_down;
    logic display_off;
  } cfg_t;

  // active-low glyph table, bit i is segment i (a = bit 0)
  function automatic seg_t glyph_lookup(input char_t ch);
    seg_t g;
    case (ch)
      8'h30:   g = 7'h40;  // 0
      8'h31:   g = 7'h79;  // 1
      8'h32:   g = 7'h24;  // 2
      8'h33:   g = 7'h30;  // 3
      8'h34:   g = 7'h19;  // 4
      8'h35:   g = 7'h12;  // 5
      8'h36:   g = 7'h02;  // 6
      8'h37:   g = 7'h78;  // 7
      8'h38:   g = 7'h00;  // 8
      8'h39:   g = 7'h10;  // 9
      8'h41:   g = 7'h08;  // A
      8'h42:   g = 7'h03;  // B
      8'h43:   g = 7'h46;  // C
      8'h44:   g = 7'h21;  // D
      8'h45:   g = 7'h06;  // E
      8'h46:   g = 7'h0E;  // F
      8'h47:   g = 7'h10;  // G
      8'h48:   g = 7'h09;  // H
      8'h49:   g = 7'h79;  // I
      8'h4A:   g = 7'h71;  // J
      8'h4B:   g = 7'h0A;  // K
      8'h4C:   g = 7'h47;  // L
      8'h4E:   g = 7'h2B;  // N
      8'h4F:   g = 7'h40;  // O
      8'h50:   g = 7'h0C;  // P
      8'h51:   g = 7'h18;  // Q
      8'h52:   g = 7'h2F;  // R
      8'h53:   g = 7'h12;  // S
      8'h54:   g = 7'h07;  // T
      8'h55:   g = 7'h41;  // U
      8'h56:   g = 7'h63;  // V
      8'h58:   g = 7'h1B;  // X
      8'h59:   g = 7'h11;  // Y
      8'h5A:   g = 7'h24;  // Z
      default: g = SEG_BLANK;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

[rtl/core/ssge_lane.sv]
`default_nettype none
module ssge_lane
  import ssge_pkg::*;
(
  input  char_t  char_i,
  input  shift_t shift_i,
  input  cfg_t   cfg_i,
  output seg_t   seg_o
);

  seg_t lit;
  seg_t lit_flip;
  seg_t res;

  // work in active-high form
  assign lit = ~glyph_lookup(char_i);

  // vertical flip: a<->d, b<->c, e<->f, g stays
  always_comb begin
    if (cfg_i.upside_down) begin
      lit_flip = {lit[6], lit[4], lit[5], lit[0], lit[1], lit[2], lit[3]};
    end else begin
      lit_flip = lit;
    end
  end

  always_comb begin
    res = '0;
    case (shift_i)
      SHIFT_LOWEST: begin
        res[3] = lit_flip[0];
      end
      SHIFT_LOW: begin
        res[6] = lit_flip[0];
        res[2] = lit_flip[1];
        res[4] = lit_flip[5];
        res[3] = lit_flip[6];
      end
      SHIFT_NORMAL: begin
        res = lit_flip;
      end
      SHIFT_HIGH: begin
        res[1] = lit_flip[2];
        res[6] = lit_flip[3];
        res[5] = lit_flip[4];
        res[0] = lit_flip[6];
      end
      default: begin
        res[0] = lit_flip[3];
      end
    endcase
  end

  assign seg_o = ~res;

endmodule
`default_nettype wire

[rtl/core/ssge_merge.sv]
`default_nettype none
module ssge_merge
  import ssge_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  seg_t [NUM_DIGITS-1:0] lane_seg_i,
  input  cfg_t                  cfg_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [M_TDATA_W-1:0]  out_data_o
);

  logic [M_TDATA_W-1:0] packed_w;
  logic [M_TDATA_W-1:0] out_q, out_d;
  logic [M_TDATA_W-1:0] skid_q, skid_d;
  logic                 out_vld_q, out_vld_d;
  logic                 skid_vld_q, skid_vld_d;
  logic                 accept;

  // pack lanes, display-off blanks every digit
  always_comb begin
    packed_w = '0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      packed_w[k*SEG_W +: SEG_W] = cfg_i.display_off ? SEG_BLANK : lane_seg_i[k];
    end
  end

  assign in_ready_o = ~skid_vld_q;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    out_d      = out_q;
    skid_d     = skid_q;
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (!out_vld_q || out_ready_i) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_d     = packed_w;
        out_vld_d = accept;
      end
    end else if (accept) begin
      skid_d     = packed_w;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

[rtl/core/seven_segment_glyph_encoder.sv]
// channel   | dir | handshake                      | payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready  | six character bytes, shift state
// m_axis    | out | m_axis_tvalid / m_axis_tready  | six active-low segment patterns
// cfg       | in  | cfg_we_i (no wait)             | cfg_idx_i, cfg_data_i
//
// one transaction per cycle unless m_axis stalls, each accepted result is registered
// six glyph lanes are combinational, the merge stage holds the only data registers
// a two-entry output/skid pair lets s_axis take a transaction while m_axis stalls
// s_axis_tready drops only once both entries hold results
// reset clears the config registers (flip off, display on) and empties the output
`default_nettype none
module seven_segment_glyph_encoder
  import ssge_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave side
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // char_digit5 [7:0], char_digit4 [15:8], char_digit3 [23:16], char_digit2 [31:24],
  // char_digit1 [39:32], char_digit0 [47:40], shift_state [50:48], zero pad [55:51]
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // master side
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // seg_digit5 [6:0], seg_digit4 [13:7], seg_digit3 [20:14], seg_digit2 [27:21],
  // seg_digit1 [34:28], seg_digit0 [41:35], zero pad [47:42]
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic   upside_down_q, upside_down_d;
  logic   display_off_q, display_off_d;
  cfg_t   cfg;
  shift_t shift;
  seg_t [NUM_DIGITS-1:0] lane_seg;

  // register writes
  always_comb begin
    upside_down_d = upside_down_q;
    display_off_d = display_off_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_UPSIDE_DOWN: upside_down_d = cfg_data_i[0];
        REG_DISPLAY_OFF: display_off_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upside_down_q <= 1'b0;
      display_off_q <= 1'b0;
    end else begin
      upside_down_q <= upside_down_d;
      display_off_q <= display_off_d;
    end
  end

  assign cfg.upside_down = upside_down_q;
  assign cfg.display_off = display_off_q;

  // shift state is shared by all digits
  assign shift = s_axis_tdata[NUM_DIGITS*CHAR_W +: SHIFT_W];

  // one glyph lane per digit, lane k serves the k-th packed character
  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_lane
    ssge_lane u_lane (
      .char_i  (s_axis_tdata[k*CHAR_W +: CHAR_W]),
      .shift_i (shift),
      .cfg_i   (cfg),
      .seg_o   (lane_seg[k])
    );
  end

  // pack, apply display-off, register with skid
  ssge_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .lane_seg_i  (lane_seg),
    .cfg_i       (cfg),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire

[rtl/core/ssge_checker.sv]
`default_nettype none
module ssge_checker
  import ssge_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [M_TDATA_W-1:0]  m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

  // padding above the six patterns stays zero
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:NUM_DIGITS*SEG_W] == '0)
    else $error("output padding not zero");

  // input back-pressure only while a result is pending
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("tready low with empty output");

  // a transaction into an empty block shows up next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> m_axis_tvalid)
    else $error("result missing one cycle after acceptance");

endmodule

bind seven_segment_glyph_encoder ssge_checker u_ssge_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
